>>> design/tbpc_pkg.sv
// Shared types and constants for the timed button press controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tbpc_pkg;

   localparam int NUM_CHANNELS_DEF = 5;
   localparam int CHAN_W           = 3;
   localparam int DUR_W            = 31;
   localparam int NOW_W            = 63;
   localparam int DEADLINE_W       = 64;
   localparam int MS_SCALE_W       = 20;
   localparam int PROD_W           = MS_SCALE_W + DUR_W;
   localparam int QUEUE_DEPTH      = 2;
   localparam int REQ_TDATA_W      = 104;
   localparam int RSP_TDATA_W      = 40;

   localparam logic [MS_SCALE_W-1:0] MS_TO_NS = 20'd1000000;

   typedef enum logic [1:0] {
      CMD_TIMED_HOLD  = 2'd0,
      CMD_MANUAL_SET  = 2'd1,
      CMD_ACK_ARM     = 2'd2,
      CMD_TIME_CHECK  = 2'd3
   } cmd_type;

   // Decoded event as it sits in the queue; the duration is already normalized.
   typedef struct packed {
      cmd_type            cmd;
      logic [CHAN_W-1:0]  channel;
      logic               desired;
      logic               ack;
      logic [DUR_W-1:0]   dur;
      logic [NOW_W-1:0]   now;
   } item_type;

   typedef struct packed {
      logic               valid;
      item_type           item;
   } push_type;

   typedef struct packed {
      logic               full;
      logic               valid;
   } queue_status_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic               pressed;
      logic               arm;
      logic [DUR_W-1:0]   dur;
      logic               last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_APPLY,
      ST_SCAN,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

>>> design/timed_button_press_controller_top.sv
// Top level of the timed button press controller: front end, event queue
// and back end. Depends on tbpc_pkg, tbpc_front, tbpc_queue, tbpc_back.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_tvalid/req_tready | tdata: event fields, tuser: command
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata: button change, tlast: last of event
//
// A timed press, manual set or acknowledgement passes through the back-end steps
// fetch, duration multiply and update; a time check is fetched, then scans the
// timer slots one per cycle and sends each release it finds in a step of its own.
// The scan over the deadline registers and the single result register set the rate.
// Reset is synchronous and active high; it clears every button, timer slot and the queue.
// The two-entry queue keeps accepting events while the result register is stalled;
// the back end holds its update step and each release step while the result register
// still holds an untaken transfer, even when the event itself sends nothing.
`default_nettype none

module timed_button_press_controller_top #(
   parameter int NUM_CHANNELS = tbpc_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // channel[2:0], desired[3], ack flag[4], duration[36:5],
   // now_ns[99:37], zero fill [103:100]
   input  wire logic [tbpc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_channel[2:0], out_pressed[3], arm_request[4], out_duration[35:5],
   // zero fill [39:36]
   output logic [tbpc_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                    rsp_tlast
);

   tbpc_pkg::queue_status_type   q_status;
   tbpc_pkg::push_type           push;
   tbpc_pkg::item_type           head;
   tbpc_pkg::result_type         rsp;
   logic                         pop;

   // Decodes the request and filters out events for absent channels.
   tbpc_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push)
   );

   // Decouples request acceptance from execution.
   tbpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .q_status (q_status),
      .head     (head)
   );

   // Holds all button and timer state and produces the result transfers.
   tbpc_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {4'b0000, rsp.dur, rsp.arm, rsp.pressed, rsp.channel};
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire

>>> design/tbpc_front.sv
// Front end: takes request transfers, normalizes the duration, drops
// events for channels that do not exist and pushes the rest. Uses tbpc_pkg.
`default_nettype none

module tbpc_front #(
   parameter int NUM_CHANNELS = tbpc_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [tbpc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic [1:0]                           req_tuser,
   input  wire tbpc_pkg::queue_status_type           q_status,
   output tbpc_pkg::push_type                        push
);

   logic [31:0]                   raw_dur;
   logic [tbpc_pkg::DUR_W-1:0]    norm_dur;
   logic                          chan_ok;
   tbpc_pkg::item_type            item;

   assign raw_dur  = req_tdata[36:5];
   // Zero and negative durations count as one millisecond.
   assign norm_dur = (raw_dur == 32'd0 || raw_dur[31]) ? 31'd1 : raw_dur[30:0];
   assign chan_ok  = {1'b0, req_tdata[2:0]} < 4'(NUM_CHANNELS);

   always_comb begin
      item.cmd     = tbpc_pkg::cmd_type'(req_tuser);
      item.channel = req_tdata[2:0];
      item.desired = req_tdata[3];
      item.ack     = req_tdata[4];
      item.dur     = norm_dur;
      item.now     = req_tdata[99:37];
   end

   assign req_tready = !q_status.full;

   always_comb begin
      push.item  = item;
      push.valid = req_tvalid && !q_status.full
                   && (item.cmd == tbpc_pkg::CMD_TIME_CHECK || chan_ok);
   end

endmodule

`default_nettype wire

>>> design/tbpc_queue.sv
// Short FIFO of decoded events between the front and back ends.
// Uses tbpc_pkg for the item and status types.
`default_nettype none

module tbpc_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tbpc_pkg::push_type          push,
   input  wire logic                        pop,
   output tbpc_pkg::queue_status_type       q_status,
   output tbpc_pkg::item_type               head
);

   localparam int PTR_W = (tbpc_pkg::QUEUE_DEPTH > 1) ? $clog2(tbpc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tbpc_pkg::QUEUE_DEPTH + 1);

   tbpc_pkg::item_type   mem_ff [tbpc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(tbpc_pkg::QUEUE_DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign head           = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !q_status.full;
   assign do_pop  = pop && q_status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tbpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tbpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

>>> design/tbpc_back.sv
// Back end: owns the per-channel button and timer state, executes events
// one at a time and drives the result register. Uses tbpc_pkg.
`default_nettype none

module tbpc_back #(
   parameter int NUM_CHANNELS = tbpc_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tbpc_pkg::queue_status_type          q_status,
   input  wire tbpc_pkg::item_type                  head,
   output logic                                     pop,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output tbpc_pkg::result_type                     rsp
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DW   = tbpc_pkg::DUR_W;
   localparam int TW   = tbpc_pkg::DEADLINE_W;
   localparam int PW   = tbpc_pkg::PROD_W;

   tbpc_pkg::back_state_type   state_ff, state_in;
   tbpc_pkg::item_type         item_ff, item_in;
   logic [PW-1:0]              prod_ff, prod_in;
   logic [CH_W-1:0]            idx_ff, idx_in;
   logic [NUM_CHANNELS-1:0]    rel_mask_ff, rel_mask_in;
   logic [NUM_CHANNELS-1:0]    pressed_ff, pressed_in;
   logic [NUM_CHANNELS-1:0]    running_ff, running_in;
   logic [NUM_CHANNELS-1:0]    pending_ff, pending_in;
   logic [DW-1:0]              pend_dur_ff [NUM_CHANNELS];
   logic [DW-1:0]              pend_dur_in [NUM_CHANNELS];
   logic [TW-1:0]              deadline_ff [NUM_CHANNELS];
   logic [TW-1:0]              deadline_in [NUM_CHANNELS];
   tbpc_pkg::result_type       rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [CH_W-1:0]            sel;
   logic [DW-1:0]              rd_pend;
   logic [TW-1:0]              rd_dead;
   logic [DW-1:0]              dsel;
   logic [TW-1:0]              sum;
   logic [TW-1:0]              now_ext;
   logic                       out_free;
   logic                       is_pressed;
   logic [NUM_CHANNELS-1:0]    low_bit;
   logic [NUM_CHANNELS-1:0]    rest;
   logic [tbpc_pkg::CHAN_W-1:0] low_chan;

   // One read address serves both the addressed channel and the scan index.
   assign sel        = (state_ff == tbpc_pkg::ST_SCAN) ? idx_ff
                                                       : item_ff.channel[CH_W-1:0];
   assign rd_pend    = pend_dur_ff[sel];
   assign rd_dead    = deadline_ff[sel];
   assign is_pressed = pressed_ff[sel];
   assign now_ext    = {1'b0, item_ff.now};
   assign sum        = now_ext + {{(TW - PW){1'b0}}, prod_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign dsel = (item_ff.cmd == tbpc_pkg::CMD_ACK_ARM && rd_pend > item_ff.dur)
                 ? rd_pend : item_ff.dur;

   // Lowest pending release and what remains after it.
   assign low_bit = rel_mask_ff & (~rel_mask_ff + 1'b1);
   assign rest    = rel_mask_ff & ~low_bit;

   always_comb begin
      low_chan = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (rel_mask_ff[i]) begin
            low_chan = tbpc_pkg::CHAN_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      rel_mask_in  = rel_mask_ff;
      pressed_in   = pressed_ff;
      running_in   = running_ff;
      pending_in   = pending_ff;
      pend_dur_in  = pend_dur_ff;
      deadline_in  = deadline_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;

      unique case (state_ff)
         tbpc_pkg::ST_IDLE: begin
            if (q_status.valid) begin
               pop     = 1'b1;
               item_in = head;
               if (head.cmd == tbpc_pkg::CMD_TIME_CHECK) begin
                  idx_in      = '0;
                  rel_mask_in = '0;
                  state_in    = tbpc_pkg::ST_SCAN;
               end else begin
                  state_in    = tbpc_pkg::ST_MUL;
               end
            end
         end

         tbpc_pkg::ST_MUL: begin
            prod_in  = tbpc_pkg::MS_TO_NS * dsel;
            state_in = tbpc_pkg::ST_APPLY;
         end

         tbpc_pkg::ST_APPLY: begin
            if (out_free) begin
               state_in = tbpc_pkg::ST_IDLE;
               unique case (item_ff.cmd)
                  tbpc_pkg::CMD_TIMED_HOLD: begin
                     if (pending_ff[sel] && is_pressed) begin
                        if (item_ff.dur > rd_pend) begin
                           pend_dur_in[sel] = item_ff.dur;
                        end
                     end else if (running_ff[sel] && is_pressed) begin
                        if (sum > rd_dead) begin
                           deadline_in[sel] = sum;
                        end
                     end else begin
                        running_in[sel]  = 1'b0;
                        pending_in[sel]  = 1'b0;
                        pend_dur_in[sel] = '0;
                        deadline_in[sel] = '0;
                        if (!is_pressed) begin
                           pressed_in[sel]  = 1'b1;
                           pending_in[sel]  = 1'b1;
                           pend_dur_in[sel] = item_ff.dur;
                           rsp_in.channel   = item_ff.channel;
                           rsp_in.pressed   = 1'b1;
                           rsp_in.arm       = 1'b1;
                           rsp_in.dur       = item_ff.dur;
                           rsp_in.last      = 1'b1;
                           rsp_valid_in     = 1'b1;
                        end
                     end
                  end
                  tbpc_pkg::CMD_MANUAL_SET: begin
                     if (item_ff.desired || !(running_ff[sel] || pending_ff[sel])
                         || !is_pressed) begin
                        running_in[sel]  = 1'b0;
                        pending_in[sel]  = 1'b0;
                        pend_dur_in[sel] = '0;
                        deadline_in[sel] = '0;
                     end
                     // A release is held back while a timer owns the channel.
                     if ((item_ff.desired && !is_pressed)
                         || (!item_ff.desired && is_pressed
                             && !(running_ff[sel] || pending_ff[sel]))) begin
                        pressed_in[sel] = item_ff.desired;
                        rsp_in.channel  = item_ff.channel;
                        rsp_in.pressed  = item_ff.desired;
                        rsp_in.arm      = 1'b0;
                        rsp_in.dur      = '0;
                        rsp_in.last     = 1'b1;
                        rsp_valid_in    = 1'b1;
                     end
                  end
                  tbpc_pkg::CMD_ACK_ARM: begin
                     if (item_ff.ack && pending_ff[sel] && is_pressed) begin
                        running_in[sel]  = 1'b1;
                        pending_in[sel]  = 1'b0;
                        pend_dur_in[sel] = '0;
                        deadline_in[sel] = sum;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         tbpc_pkg::ST_SCAN: begin
            if (running_ff[sel] && now_ext >= rd_dead) begin
               running_in[sel]  = 1'b0;
               pending_in[sel]  = 1'b0;
               pend_dur_in[sel] = '0;
               deadline_in[sel] = '0;
               if (is_pressed) begin
                  pressed_in[sel]  = 1'b0;
                  rel_mask_in[sel] = 1'b1;
               end
            end
            if (idx_ff == CH_W'(NUM_CHANNELS - 1)) begin
               state_in = (rel_mask_in != '0) ? tbpc_pkg::ST_EMIT : tbpc_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         tbpc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_in.channel = low_chan;
               rsp_in.pressed = 1'b0;
               rsp_in.arm     = 1'b0;
               rsp_in.dur     = '0;
               rsp_in.last    = (rest == '0);
               rsp_valid_in   = 1'b1;
               rel_mask_in    = rest;
               if (rest == '0) begin
                  state_in = tbpc_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = tbpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbpc_pkg::ST_IDLE;
         pressed_ff   <= '0;
         running_ff   <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pend_dur_ff[i] <= '0;
            deadline_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pressed_ff   <= pressed_in;
         running_ff   <= running_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_dur_ff  <= pend_dur_in;
         deadline_ff  <= deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      idx_ff      <= idx_in;
      rel_mask_ff <= rel_mask_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

>>> design/tbpc_checker.sv
// Port-level checks for the timed button press controller, bound to the top
// level. Depends on tbpc_pkg and timed_button_press_controller_top.
`default_nettype none

module tbpc_checker #(
   parameter int NUM_CHANNELS = tbpc_pkg::NUM_CHANNELS_DEF
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [tbpc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // A result offered but not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transfer dropped while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Only a press can ask for a timer to be armed.
   a_arm_is_press: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3])
      else $error("arm request on a release");

   // A release never carries a duration.
   a_release_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[35:5] == '0)
      else $error("release carries a duration");

   // Results name only channels that exist.
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, rsp_tdata[2:0]} < 4'(NUM_CHANNELS))
      else $error("result for a channel that does not exist");

endmodule

bind timed_button_press_controller_top tbpc_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_tbpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for timed_button_press_controller_top: directed and random
// button events with a cycle-free predictor. Depends on tbpc_pkg and the design sources.

module tb;

   localparam int          NUM_CH       = tbpc_pkg::NUM_CHANNELS_DEF;
   localparam int          IDLE_PCT     = 18;
   localparam int          DRAIN_CYCLES = 40;
   localparam logic [63:0] MS_TO_NS_64  = 64'd1_000_000;
   localparam logic [62:0] NOW_MAX      = {63{1'b1}};

   // One input event as the sender sees it, duration still raw and signed.
   typedef struct packed {
      tbpc_pkg::cmd_type cmd;
      logic [2:0]  channel;
      logic        desired;
      logic        ack;
      logic [31:0] duration;
      logic [62:0] now_ns;
   } button_event_type;

   // One change of a button as it leaves the block.
   typedef struct packed {
      logic [2:0]  channel;
      logic        pressed;
      logic        arm;
      logic [30:0] dur;
      logic        last;
   } button_change_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [tbpc_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]                       req_tuser = 2'd0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [tbpc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;

   // Predicted button and timer state.
   logic [NUM_CH-1:0] button_down;
   logic              timer_on   [NUM_CH];
   logic              arm_wait   [NUM_CH];
   logic [31:0]       held_dur   [NUM_CH];
   logic [63:0]       deadline   [NUM_CH];

   button_change_type expected_changes [$];
   int                mismatches  = 0;
   int                events_sent = 0;
   logic              steady_flow = 1'b0;
   logic [62:0]       scene_ns    = 63'd1_000_000_000;

   timed_button_press_controller_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("timed_button_press_controller_top test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [31:0] clamp_duration(logic [31:0] raw);
      if (raw == 32'd0 || raw[31])
         return 32'd1;
      return raw;
   endfunction

   function automatic void clear_timer_slot(int c);
      timer_on[c] = 1'b0;
      arm_wait[c] = 1'b0;
      held_dur[c] = 32'd0;
      deadline[c] = 64'd0;
   endfunction

   function automatic button_change_type change(int c, logic pr, logic arm, logic [31:0] dur);
      button_change_type chg;
      chg.channel = c[2:0];
      chg.pressed = pr;
      chg.arm     = arm;
      chg.dur     = dur[30:0];
      chg.last    = 1'b0;
      return chg;
   endfunction

   function automatic void apply_button_event(button_event_type ev);
      button_change_type burst [0:NUM_CH-1];
      int                n;
      int                c;
      int                ch;
      logic              was_down;
      logic [31:0]       dur;
      logic [31:0]       longest;
      logic [63:0]       stamp;
      n   = 0;
      dur = clamp_duration(ev.duration);
      if (ev.cmd == tbpc_pkg::CMD_TIME_CHECK) begin
         // Expired slots are cleared in channel order; only pressed ones report.
         for (c = 0; c < NUM_CH; c++) begin
            if (!timer_on[c] || {1'b0, ev.now_ns} < deadline[c])
               continue;
            clear_timer_slot(c);
            if (!button_down[c])
               continue;
            button_down[c] = 1'b0;
            burst[n] = change(c, 1'b0, 1'b0, 32'd0);
            n++;
         end
      end else if (ev.channel < NUM_CH) begin
         ch       = ev.channel;
         was_down = button_down[ch];
         case (ev.cmd)
            tbpc_pkg::CMD_TIMED_HOLD: begin
               if (arm_wait[ch] && was_down) begin
                  if (dur > held_dur[ch])
                     held_dur[ch] = dur;
               end else if (timer_on[ch] && was_down) begin
                  stamp = {1'b0, ev.now_ns} + MS_TO_NS_64 * {32'd0, dur};
                  if (stamp > deadline[ch])
                     deadline[ch] = stamp;
               end else begin
                  clear_timer_slot(ch);
                  if (!was_down) begin
                     button_down[ch] = 1'b1;
                     arm_wait[ch]    = 1'b1;
                     held_dur[ch]    = dur;
                     burst[n] = change(ch, 1'b1, 1'b1, dur);
                     n++;
                  end
               end
            end
            tbpc_pkg::CMD_MANUAL_SET: begin
               if (ev.desired) begin
                  clear_timer_slot(ch);
                  if (!was_down) begin
                     button_down[ch] = 1'b1;
                     burst[n] = change(ch, 1'b1, 1'b0, 32'd0);
                     n++;
                  end
               end else if (timer_on[ch] || arm_wait[ch]) begin
                  // A timer owns the channel, so the release is held back.
                  if (!was_down)
                     clear_timer_slot(ch);
               end else begin
                  clear_timer_slot(ch);
                  if (was_down) begin
                     button_down[ch] = 1'b0;
                     burst[n] = change(ch, 1'b0, 1'b0, 32'd0);
                     n++;
                  end
               end
            end
            default: begin
               if (ev.ack && arm_wait[ch] && was_down) begin
                  longest      = (held_dur[ch] > dur) ? held_dur[ch] : dur;
                  timer_on[ch] = 1'b1;
                  arm_wait[ch] = 1'b0;
                  held_dur[ch] = 32'd0;
                  deadline[ch] = {1'b0, ev.now_ns} + MS_TO_NS_64 * {32'd0, longest};
               end
            end
         endcase
      end
      for (c = 0; c < n; c++) begin
         burst[c].last = (c == n - 1);
         expected_changes.insert(expected_changes.size(), burst[c]);
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin : result_check
      button_change_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_changes.size() == 0) begin
            report_mismatch("transfer with nothing expected", 64'd0, {24'd0, rsp_tdata});
         end else begin
            want = expected_changes.pop_front();
            if (rsp_tdata[2:0] != want.channel)
               report_mismatch("out_channel", 64'(want.channel), 64'(rsp_tdata[2:0]));
            if (rsp_tdata[3] != want.pressed)
               report_mismatch("out_pressed", 64'(want.pressed), 64'(rsp_tdata[3]));
            if (rsp_tdata[4] != want.arm)
               report_mismatch("arm_request", 64'(want.arm), 64'(rsp_tdata[4]));
            if (rsp_tdata[35:5] != want.dur)
               report_mismatch("out_duration", 64'(want.dur), 64'(rsp_tdata[35:5]));
            if (rsp_tlast != want.last)
               report_mismatch("tlast", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   // The result side stalls at random except during the steady stretch.
   always @(negedge clock) begin
      if (reset)
         rsp_tready = 1'b0;
      else
         rsp_tready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic send_event(input button_event_type ev);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = ev.cmd;
      req_tdata  = {4'd0, ev.now_ns, ev.duration, ev.ack, ev.desired, ev.channel};
      do @(posedge clock); while (!req_tready);
      apply_button_event(ev);
      events_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_fields(tbpc_pkg::cmd_type cmd, int ch, logic desired, logic ack,
                              logic [31:0] dur, logic [62:0] now);
      button_event_type ev;
      ev.cmd      = cmd;
      ev.channel  = ch[2:0];
      ev.desired  = desired;
      ev.ack      = ack;
      ev.duration = dur;
      ev.now_ns   = now;
      send_event(ev);
   endtask

   task automatic hold_press(int ch, logic [31:0] dur);
      send_fields(tbpc_pkg::CMD_TIMED_HOLD, ch, 1'b0, 1'b0, dur, scene_ns);
   endtask

   task automatic manual_set(int ch, logic desired);
      send_fields(tbpc_pkg::CMD_MANUAL_SET, ch, desired, 1'b0, 32'd0, scene_ns);
   endtask

   task automatic ack_arm(int ch, logic ack, logic [31:0] dur, logic [62:0] now);
      send_fields(tbpc_pkg::CMD_ACK_ARM, ch, 1'b0, ack, dur, now);
   endtask

   task automatic time_check(logic [62:0] now);
      send_fields(tbpc_pkg::CMD_TIME_CHECK, 0, 1'b0, 1'b0, 32'd0, now);
   endtask

   task automatic wait_until_drained();
      while (expected_changes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly small durations so that timers expire within the run, plus zero,
   // negative and full-range values.
   function automatic logic [31:0] pick_duration();
      int r;
      r = $urandom_range(99);
      if (r < 50)
         return $urandom_range(4);
      if (r < 62)
         return 32'd0;
      if (r < 75)
         return {1'b1, 31'($urandom)};
      return $urandom;
   endfunction

   function automatic logic [62:0] pick_now();
      if ($urandom_range(19) == 0)
         return 63'({$urandom, $urandom});
      return scene_ns;
   endfunction

   // One well-formed press, arm and expiry sequence on a random channel, or a
   // single noise event.
   task automatic send_random_burst();
      int ch;
      ch = ($urandom_range(15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, NUM_CH - 1);
      scene_ns = scene_ns + $urandom_range(2_000_000);
      if ($urandom_range(99) < 55) begin
         hold_press(ch, pick_duration());
         if ($urandom_range(3) == 0)
            hold_press(ch, pick_duration());
         scene_ns = scene_ns + $urandom_range(500_000);
         ack_arm(ch, $urandom_range(9) != 0, pick_duration(), pick_now());
         if ($urandom_range(3) == 0)
            hold_press(ch, pick_duration());
         if ($urandom_range(2) != 0)
            time_check(scene_ns + $urandom_range(5_000_000));
      end else begin
         send_fields(tbpc_pkg::cmd_type'($urandom_range(3)), $urandom_range(7),
                     $urandom_range(1), $urandom_range(1), pick_duration(), pick_now());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_events();
      hold_press(0, 32'd0);                       // zero duration becomes one
      hold_press(0, 32'd5);                       // extends the pending arm
      ack_arm(0, 1'b0, 32'd9, 63'd1000);          // ack flag clear: ignored
      ack_arm(0, 1'b1, 32'hFFFF_FFF9, 63'd2000);  // negative duration, pending 5 wins
      hold_press(0, 32'd10);                      // stretches the running deadline
      manual_set(0, 1'b0);                        // held back by the timer
      manual_set(1, 1'b1);
      manual_set(1, 1'b1);                        // already down: no change
      ack_arm(1, 1'b1, 32'd1, 63'd0);             // nothing pending
      hold_press(1, 32'd3);                       // pressed without a timer
      manual_set(2, 1'b0);                        // already up
      hold_press(2, 32'h7FFF_FFFF);
      ack_arm(2, 1'b1, 32'h8000_0000, NOW_MAX);   // largest deadline
      hold_press(3, 32'hFFFF_FFFF);
      ack_arm(3, 1'b1, 32'd2, 63'd4000);
      send_fields(tbpc_pkg::CMD_TIMED_HOLD, 5, 1'b1, 1'b1, 32'd1, 63'd0);  // out of range
      send_fields(tbpc_pkg::CMD_MANUAL_SET, 6, 1'b1, 1'b1, 32'd1, 63'd0);
      send_fields(tbpc_pkg::CMD_ACK_ARM, 7, 1'b1, 1'b1, 32'd1, 63'd0);
      time_check(63'd0);
      time_check(63'd10_003_000);                 // releases channel 3; channel 0 was stretched
      manual_set(1, 1'b0);
      time_check(NOW_MAX);                        // releases channel 0; channel 2 not due
      manual_set(2, 1'b1);                        // takes the channel from its timer
      manual_set(2, 1'b0);
   endtask

   // Every channel expires at the same check, so five releases come in a row.
   task automatic test_all_channels_expire();
      int c;
      for (c = 0; c < NUM_CH; c++)
         hold_press(c, 32'd1);
      for (c = 0; c < NUM_CH; c++)
         ack_arm(c, 1'b1, 32'd0, scene_ns);
      time_check(scene_ns + 63'd1_000_000);
   endtask

   task automatic test_random_events(int count);
      int stop_at;
      stop_at = events_sent + count;
      while (events_sent < stop_at)
         send_random_burst();
   endtask

   // The sender holds off until every expected result has been seen.
   task automatic test_drain_pause();
      repeat (6) send_random_burst();
      while (expected_changes.size() != 0)
         @(posedge clock);
      @(negedge clock);
      repeat (6) send_random_burst();
   endtask

   task automatic test_steady_stream(int count);
      steady_flow = 1'b1;
      test_random_events(count);
      steady_flow = 1'b0;
   endtask

   initial begin
      button_down = '0;
      for (int c = 0; c < NUM_CH; c++)
         clear_timer_slot(c);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_events();
      test_all_channels_expire();
      test_random_events(130);
      test_drain_pause();
      test_steady_stream(60);
      test_random_events(110);

      wait_until_drained();
      if (mismatches == 0)
         $display("timed_button_press_controller_top test passed");
      else
         $display("timed_button_press_controller_top test failed");
      $finish;
   end

endmodule

>>> files.f
design/tbpc_pkg.sv
design/tbpc_front.sv
design/tbpc_queue.sv
design/tbpc_back.sv
design/timed_button_press_controller_top.sv
design/tbpc_checker.sv
tb/tb.sv
